/* rtl/core/u8d_pkg.sv */
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; every other file in rtl/core imports this package.
package u8d_pkg;

    // Lead byte class masks and continuation marker.
    localparam logic [7:0]  LEAD4_MASK       = 8'hF0;
    localparam logic [7:0]  LEAD3_MASK       = 8'hE0;
    localparam logic [7:0]  LEAD2_MASK       = 8'hC0;
    localparam logic [7:0]  CONT_MARK        = 8'h80;
    localparam logic [7:0]  LOW7_MASK        = 8'h7F;
    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

    // Bytes still expected after each lead class.
    localparam logic [1:0]  NEED_NONE = 2'd0;
    localparam logic [1:0]  NEED_ONE  = 2'd1;
    localparam logic [1:0]  NEED_TWO  = 2'd2;
    localparam logic [1:0]  NEED_THREE = 2'd3;

    // One input word.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        bad_sequence;
    } out_word_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]  bytes_still_needed;
        logic [15:0] partial_value;
        logic        continuations_ok;
    } dec_state_t;

    localparam dec_state_t STATE_IDLE = '{
        bytes_still_needed: NEED_NONE,
        partial_value:      16'h0000,
        continuations_ok:   1'b1
    };

endpackage

/* rtl/core/u8d_step.sv */
// Combinational per-byte update of the UTF-8 decoder state and result.
// Depends on u8d_pkg for word and state types.
module u8d_step (
    input  u8d_pkg::in_word_t   in_word,
    input  u8d_pkg::dec_state_t cur_state,
    output u8d_pkg::dec_state_t next_state,
    output logic                res_valid,
    output u8d_pkg::out_word_t  res_word
);
    import u8d_pkg::*;

    logic [7:0]  b;
    logic [1:0]  left;
    logic [15:0] part;
    logic [15:0] shifted;
    logic [15:0] sum;
    logic        ok_now;

    assign b = in_word.in_byte;

    // Continuation contribution: (byte - 0x80) shifted by six bits per byte left.
    always_comb begin
        left = cur_state.bytes_still_needed - 2'd1;
        part = {8'h00, b} - {8'h00, CONT_MARK};
        case (left)
            2'd0:    shifted = part;
            2'd1:    shifted = {part[9:0], 6'b0};
            default: shifted = {part[3:0], 12'b0};
        endcase
        sum    = cur_state.partial_value + shifted;
        ok_now = cur_state.continuations_ok & b[7];
    end

    // Classify the byte and form the next state and any result.
    always_comb begin
        next_state = cur_state;
        res_valid  = 1'b0;
        res_word   = '{code_unit: 16'h0000, bad_sequence: 1'b0};

        if (cur_state.bytes_still_needed != NEED_NONE) begin
            next_state.bytes_still_needed = left;
            next_state.partial_value      = sum;
            next_state.continuations_ok   = ok_now;
            if (left == NEED_NONE) begin
                res_valid = 1'b1;
                if (ok_now) begin
                    res_word = '{code_unit: sum, bad_sequence: 1'b0};
                end else begin
                    res_word = '{code_unit: REPLACEMENT_UNIT, bad_sequence: 1'b1};
                end
                next_state = STATE_IDLE;
            end
        end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
            // The lead's part is a multiple of 65536 and vanishes in 16 bits.
            next_state.bytes_still_needed = NEED_THREE;
            next_state.partial_value      = 16'h0000;
            next_state.continuations_ok   = 1'b1;
        end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
            // Here byte - 0xE0 is just the low nibble.
            next_state.bytes_still_needed = NEED_TWO;
            next_state.partial_value      = {b[3:0], 12'b0};
            next_state.continuations_ok   = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
            // Here byte - 0xC0 is just the low five bits.
            next_state.bytes_still_needed = NEED_ONE;
            next_state.partial_value      = {5'b0, b[4:0], 6'b0};
            next_state.continuations_ok   = 1'b1;
        end else if ((b & CONT_MARK) == CONT_MARK) begin
            // A stray continuation byte emits its low seven bits.
            res_valid = 1'b1;
            res_word  = '{code_unit: {8'h00, b & LOW7_MASK}, bad_sequence: 1'b0};
        end else begin
            res_valid = 1'b1;
            res_word  = '{code_unit: {8'h00, b}, bad_sequence: 1'b0};
        end

        // End of stream drops whatever is still pending.
        if (in_word.end_of_stream) begin
            next_state = STATE_IDLE;
        end
    end

endmodule

/* rtl/core/u8d_out_reg.sv */
// Result register of the UTF-8 decoder with valid/ready output handshake.
// Depends on u8d_pkg for the result word type.
module u8d_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u8d_pkg::out_word_t load_word,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output u8d_pkg::out_word_t m_data
);
    import u8d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t data_reg;

    // The register may take a new word when empty or when its word leaves now.
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* rtl/core/utf8_byte_stream_decoder.sv */
// Top level of the UTF-8 byte stream decoder.
// Depends on u8d_pkg, u8d_step and u8d_out_reg.

// The decoder takes one UTF-8 byte per input word and returns at most one
// 16-bit code unit per byte: ASCII passes through, a stray continuation
// byte gives its low seven bits, and a 2-, 3- or 4-byte sequence gives its
// value truncated to 16 bits on its final byte, or 0xFFFD with
// bad_sequence set when a continuation byte lacked bit 7. A byte marked
// end_of_stream drops any sequence still pending after it. The block takes
// one byte every clock cycle; a byte passes through an input register, the
// combinational state update and a result register before its result word
// is presented on the output. A stalled result word holds back the next
// byte. The state update loop is what sets the rate.
module utf8_byte_stream_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  u8d_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output u8d_pkg::out_word_t m_data
);
    import u8d_pkg::*;

    logic       in_valid_reg;
    in_word_t   in_data_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       res_valid;
    out_word_t  res_word;
    logic       can_load;
    logic       advance;

    // The registered byte is processed when the result register has room.
    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    // Input register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Decoder state, updated once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    u8d_step u_step (
        .in_word    (in_data_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .res_valid  (res_valid),
        .res_word   (res_word)
    );

    u8d_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_word (res_word),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* test/u8d_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the UTF-8 byte stream decoder testbench.
// Watches both channels, predicts each code unit and compares; uses u8d_pkg.
module u8d_result_checker
    import u8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatch_count,
    output int        units_outstanding
);

    // Predicted decoder state and the code units still owed by the block.
    dec_state_t decoder;
    out_word_t  expected_units[$];

    assign units_outstanding = expected_units.size();

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Advance the predicted decoder by one byte and queue any code unit it yields.
    task automatic decode_byte(input in_word_t w);
        logic [1:0]  left;
        logic [15:0] part;
        logic        emit;
        out_word_t   unit;
        emit = 1'b0;
        unit = '0;
        if (decoder.bytes_still_needed != NEED_NONE) begin
            // Any byte counts as a continuation here; only bit 7 is checked.
            left = decoder.bytes_still_needed - 2'd1;
            part = {8'h00, w.in_byte} - {8'h00, CONT_MARK};
            if (!w.in_byte[7]) begin
                decoder.continuations_ok = 1'b0;
            end
            decoder.partial_value = decoder.partial_value + (part << (left * 6));
            decoder.bytes_still_needed = left;
            if (left == NEED_NONE) begin
                emit = 1'b1;
                if (decoder.continuations_ok) begin
                    unit.code_unit = decoder.partial_value;
                    unit.bad_sequence = 1'b0;
                end else begin
                    unit.code_unit = REPLACEMENT_UNIT;
                    unit.bad_sequence = 1'b1;
                end
                decoder = STATE_IDLE;
            end
        end else if ((w.in_byte & LEAD4_MASK) == LEAD4_MASK) begin
            // The lead's weighted part is a multiple of 65536 and drops out.
            decoder = STATE_IDLE;
            decoder.bytes_still_needed = NEED_THREE;
        end else if ((w.in_byte & LEAD3_MASK) == LEAD3_MASK) begin
            decoder = STATE_IDLE;
            decoder.partial_value = ({8'h00, w.in_byte} - {8'h00, LEAD3_MASK}) << 12;
            decoder.bytes_still_needed = NEED_TWO;
        end else if ((w.in_byte & LEAD2_MASK) == LEAD2_MASK) begin
            decoder = STATE_IDLE;
            decoder.partial_value = ({8'h00, w.in_byte} - {8'h00, LEAD2_MASK}) << 6;
            decoder.bytes_still_needed = NEED_ONE;
        end else if ((w.in_byte & CONT_MARK) == CONT_MARK) begin
            // A stray continuation byte gives its low seven bits.
            emit = 1'b1;
            unit.code_unit = {8'h00, w.in_byte & LOW7_MASK};
        end else begin
            emit = 1'b1;
            unit.code_unit = {8'h00, w.in_byte};
        end
        // End of stream drops whatever is still pending.
        if (w.end_of_stream) begin
            decoder = STATE_IDLE;
        end
        if (emit) begin
            expected_units.push_back(unit);
        end
    endtask

    // Sample both channels at each rising edge, before the edge's updates land.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            decoder = STATE_IDLE;
            expected_units.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_units.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_data), 0);
                end else begin
                    want = expected_units.pop_front();
                    if (m_data.code_unit != want.code_unit) begin
                        report_mismatch("code_unit", int'(m_data.code_unit),
                                        int'(want.code_unit));
                    end
                    if (m_data.bad_sequence != want.bad_sequence) begin
                        report_mismatch("bad_sequence", int'(m_data.bad_sequence),
                                        int'(want.bad_sequence));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data);
            end
        end
    end

endmodule

/* test/tb_utf8_byte_stream_decoder.sv */
`timescale 1ns / 100ps
// Top of the UTF-8 byte stream decoder testbench: clock, reset, byte stimulus
// and the verdict. Depends on u8d_pkg, the decoder RTL and u8d_result_checker.
module tb_utf8_byte_stream_decoder;
    import u8d_pkg::*;

    localparam int RANDOM_WORDS = 1450;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        mismatch_count;
    int        units_outstanding;
    bit        gaps_on = 1'b1;
    int        words_sent = 0;

    utf8_byte_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    u8d_result_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .mismatch_count    (mismatch_count),
        .units_outstanding (units_outstanding)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The result side stalls now and then while gaps are enabled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= gaps_on ? ($urandom_range(99) >= 12) : 1'b1;
        end
    end

    // Offer one byte, with an occasional idle gap first, and wait for acceptance.
    task automatic send_word(input logic [7:0] b, input logic eos);
        in_word_t w;
        w.in_byte = b;
        w.end_of_stream = eos;
        while (gaps_on && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        words_sent++;
    endtask

    // A continuation byte, sometimes missing bit 7.
    function automatic logic [7:0] pick_continuation();
        if ($urandom_range(99) < 10) begin
            return 8'($urandom_range(8'h7F));
        end
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    // One random sequence, mostly well formed, sometimes plain noise.
    task automatic send_random_sequence();
        int          len;
        logic [7:0]  lead;
        if ($urandom_range(99) < 25) begin
            send_word(8'($urandom_range(255)), $urandom_range(99) < 3);
        end else begin
            len = $urandom_range(4, 1);
            case (len)
                1: lead = 8'($urandom_range(8'h7F));
                2: lead = 8'($urandom_range(8'hDF, 8'hC0));
                3: lead = 8'($urandom_range(8'hEF, 8'hE0));
                default: lead = 8'($urandom_range(8'hFF, 8'hF0));
            endcase
            send_word(lead, $urandom_range(99) < 3);
            for (int i = 1; i < len; i++) begin
                send_word(pick_continuation(), $urandom_range(99) < 3);
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // ASCII and stray continuation extremes.
        send_word(8'h00, 1'b0); send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0); send_word(8'hBF, 1'b0);
        // Two-byte sequence ending on an end-of-stream byte.
        send_word(8'hC3, 1'b0); send_word(8'hA9, 1'b1);
        // Three- and four-byte sequences.
        send_word(8'hE2, 1'b0); send_word(8'h82, 1'b0); send_word(8'hAC, 1'b0);
        send_word(8'hF0, 1'b0); send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0); send_word(8'h80, 1'b0);
        // A lead byte above 0xF7 still opens a four-byte sequence.
        send_word(8'hFF, 1'b0); send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0); send_word(8'hBF, 1'b0);
        // Continuation without bit 7 gives the replacement unit.
        send_word(8'hC3, 1'b0); send_word(8'h41, 1'b0);
        // End of stream in the middle of a sequence drops it.
        send_word(8'hE2, 1'b0); send_word(8'h82, 1'b1);
        // A lead-like byte inside a sequence counts as a continuation.
        send_word(8'hC3, 1'b0); send_word(8'hC3, 1'b0);
        // End of stream on a lead byte, then on plain ASCII.
        send_word(8'hF5, 1'b1); send_word(8'h41, 1'b1);

        // Random sequences, with a long stretch that has no idling at all.
        while (words_sent < 25 + RANDOM_WORDS) begin
            gaps_on = !(words_sent >= 500 && words_sent < 800);
            send_random_sequence();
        end
        s_valid <= 1'b0;
        gaps_on = 1'b1;

        // Drain the outstanding code units, then allow the pipeline to settle.
        @(posedge aclk);
        while (units_outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && units_outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
